FILE: hw/rtl/quadrature_encoder_speed_meter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature encoder speed meter
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_SPEED_METER_MACROS_SVH
`define QUADRATURE_ENCODER_SPEED_METER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define QESM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QESM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qesm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesm_pkg
// Shared constants and codes of the quadrature encoder speed meter.
// ----------------------------------------------------------------------------
package qesm_pkg;

  localparam int COUNT_WIDTH_DEF = 24;

  // field widths
  localparam int OP_W     = 2;
  localparam int CFG_W    = 16;
  localparam int DIST_W   = 48;
  localparam int SPEED_W  = 32;
  localparam int DIR_W    = 2;
  localparam int IDX_W    = 2;
  localparam int DEN_W    = 32;
  localparam int K_W      = 12;
  localparam int FRAC_SHIFT = 24;

  // operation codes
  localparam logic [OP_W-1:0] OP_EDGE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_PRESET = 2'd2;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0]         PERIOD_RESET = 16'd200;
  localparam logic [CFG_W-1:0]         SCALE_RESET  = 16'd12800;
  localparam logic signed [DIST_W-1:0] PRESET_RESET = '0;

  // scale floor (1.0 in Q8.8) and km/h factor (3.6 * 1000 ms)
  localparam logic [CFG_W-1:0] SCALE_MIN = 16'd256;
  localparam logic [K_W-1:0]   SPEED_K   = 12'd3600;

endpackage

FILE: hw/rtl/qesm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesm_in_if
// Encoder event channel: op code and level of the opposite phase.
// ----------------------------------------------------------------------------
interface qesm_in_if;
  import qesm_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic            other_level;

  modport source (output valid, op, other_level, input ready);
  modport sink   (input valid, op, other_level, output ready);
endinterface

FILE: hw/rtl/qesm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesm_out_if
// Result channel: window flag, distance, speed and direction.
// ----------------------------------------------------------------------------
interface qesm_out_if;
  import qesm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     window_closed;
  logic signed [DIST_W-1:0] distance_out;
  logic [SPEED_W-1:0]       speed_out;
  logic [DIR_W-1:0]         direction;

  modport source (output valid, window_closed, distance_out, speed_out, direction,
                  input ready);
  modport sink   (input valid, window_closed, distance_out, speed_out, direction,
                  output ready);
endinterface

FILE: hw/rtl/qesm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qesm_cfg_if;
  import qesm_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DIST_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/qesm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesm_divider
// Shared restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module qesm_divider #(
  parameter int DIV_W = 60
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIV_W-1:0]           dividend,
  input  logic [qesm_pkg::DEN_W-1:0] divisor,
  output logic                       done,
  output logic [DIV_W-1:0]           quotient
);
  import qesm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             take;

  assign shifted = {rem, dvd[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign take    = ~diff[DEN_W];
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CNT_W'(DIV_W - 1);
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      rem <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dvd <= {dvd[DIV_W-2:0], take};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/quadrature_encoder_speed_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_speed_meter
// Counts quadrature edges per window; on window close updates speed,
// direction and (nonzero count) distance via one shared iterative divider.
// ----------------------------------------------------------------------------
// Edges, clear and ticks that do not close a window pass through ST_EMIT,
//   which loads the result when the output register is free, then back to
//   ST_IDLE. Window close with a nonzero count: two divisions on the shared
//   divider, DIV_W = max(COUNT_WIDTH + 36, 49) quotient bits each, then
//   ST_EMIT. A new item is accepted only in ST_IDLE, after the result is loaded.
// Synchronous reset clears counters, distance, speed and direction and loads
//   the register defaults (period 200, scale 50.0, preset 0).
module quadrature_encoder_speed_meter #(
  parameter int COUNT_WIDTH = qesm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  qesm_in_if.sink     items,
  qesm_out_if.source  results,
  qesm_cfg_if.sink    cfg
);
  import qesm_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int NUM_W = CW + K_W;
  localparam int DIV_W = (NUM_W + FRAC_SHIFT > DIST_W + 1) ? NUM_W + FRAC_SHIFT : DIST_W + 1;

  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [DIST_W+1:0] DMAX_EXT = {3'b000, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W+1:0] DMIN_EXT = {3'b111, {(DIST_W-1){1'b0}}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIST  = 3'd2;
  localparam logic [2:0] ST_SPEED = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;

  logic [CFG_W-1:0]         period_ms;
  logic [CFG_W-1:0]         scale_q8;
  logic signed [DIST_W-1:0] distance_preset;

  logic signed [CW-1:0]     window_count;
  logic [CFG_W-1:0]         elapsed_ticks;
  logic signed [DIST_W-1:0] distance_acc;
  logic [SPEED_W-1:0]       speed_reg;
  logic [DIR_W-1:0]         direction_reg;
  logic                     closed;
  logic                     neg;
  logic [NUM_W-1:0]         num_r;
  logic [DEN_W-1:0]         den_r;

  logic [CW-1:0]            mag;
  logic [CFG_W-1:0]         sc_eff;
  logic [CFG_W-1:0]         elapsed_inc;
  logic [NUM_W-1:0]         num_prod;
  logic [DEN_W-1:0]         den_prod;
  logic                     tick_close;
  logic                     emit_go;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DEN_W-1:0]         div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quot;

  logic signed [DIST_W+1:0] dacc_ext;
  logic signed [DIST_W+1:0] inc_ext;
  logic signed [DIST_W+1:0] dsum;
  logic signed [DIST_W-1:0] dist_sat;
  logic [SPEED_W-1:0]       speed_sat;

  assign mag         = window_count[CW-1] ? CW'(-window_count) : CW'(window_count);
  assign sc_eff      = (scale_q8 < SCALE_MIN) ? SCALE_MIN : scale_q8;
  assign elapsed_inc = (elapsed_ticks != '1) ? elapsed_ticks + 1'b1 : elapsed_ticks;
  assign num_prod    = NUM_W'(mag) * NUM_W'(SPEED_K);
  assign den_prod    = DEN_W'(sc_eff) * DEN_W'(elapsed_ticks);
  assign tick_close  = (items.op == OP_TICK) && (elapsed_inc >= period_ms);
  assign emit_go     = (state == ST_EMIT) && (!results.valid || results.ready);

  // first pass: |count| * 2^24 / scale, second pass: num * 2^24 / den
  assign div_start    = (state == ST_MUL && window_count != '0) ||
                        (state == ST_DIST && div_done);
  assign div_dividend = (state == ST_MUL) ? DIV_W'({mag, {FRAC_SHIFT{1'b0}}})
                                          : DIV_W'({num_r, {FRAC_SHIFT{1'b0}}});
  assign div_divisor  = (state == ST_MUL) ? DEN_W'(sc_eff) : den_r;

  qesm_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign dacc_ext = {{2{distance_acc[DIST_W-1]}}, distance_acc};
  assign inc_ext  = $signed({2'b00, div_quot[DIST_W-1:0]});
  assign dsum     = neg ? dacc_ext - inc_ext : dacc_ext + inc_ext;

  always_comb begin
    if (dsum > DMAX_EXT) begin
      dist_sat = DMAX_EXT[DIST_W-1:0];
    end else if (dsum < DMIN_EXT) begin
      dist_sat = DMIN_EXT[DIST_W-1:0];
    end else begin
      dist_sat = dsum[DIST_W-1:0];
    end
  end

  assign speed_sat = (|div_quot[DIV_W-1:SPEED_W]) ? '1 : div_quot[SPEED_W-1:0];

  assign items.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      period_ms       <= PERIOD_RESET;
      scale_q8        <= SCALE_RESET;
      distance_preset <= PRESET_RESET;
      window_count    <= '0;
      elapsed_ticks   <= '0;
      distance_acc    <= '0;
      speed_reg       <= '0;
      direction_reg   <= DIR_STOP;
      closed          <= 1'b0;
      results.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_PERIOD: period_ms       <= cfg.data[CFG_W-1:0];
          CFG_SCALE:  scale_q8        <= cfg.data[CFG_W-1:0];
          CFG_PRESET: distance_preset <= $signed(cfg.data);
          default: ;
        endcase
      end

      if (emit_go) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (items.valid) begin
            closed <= tick_close;
            state  <= tick_close ? ST_MUL : ST_EMIT;
            unique case (items.op)
              OP_EDGE_A: begin
                if (items.other_level && window_count != CNT_MAX) begin
                  window_count <= window_count + 1'b1;
                end
              end
              OP_EDGE_B: begin
                if (items.other_level && window_count != CNT_MIN) begin
                  window_count <= window_count - 1'b1;
                end
              end
              OP_TICK: begin
                elapsed_ticks <= elapsed_inc;
              end
              OP_CLEAR: begin
                window_count  <= '0;
                elapsed_ticks <= '0;
                distance_acc  <= distance_preset;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          num_r         <= num_prod;
          den_r         <= den_prod;
          neg           <= window_count[CW-1];
          window_count  <= '0;
          elapsed_ticks <= '0;
          if (window_count == '0) begin
            // empty window: stop, keep distance
            speed_reg     <= '0;
            direction_reg <= DIR_STOP;
            state         <= ST_EMIT;
          end else begin
            state <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (div_done) begin
            distance_acc <= dist_sat;
            state        <= ST_SPEED;
          end
        end
        ST_SPEED: begin
          if (div_done) begin
            speed_reg     <= speed_sat;
            direction_reg <= neg ? DIR_BACK : DIR_FWD;
            state         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (emit_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      results.window_closed <= closed;
      results.distance_out  <= distance_acc;
      results.speed_out     <= speed_reg;
      results.direction     <= direction_reg;
    end
  end

endmodule

FILE: hw/rtl/qesm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesm_checker
// Port-level checks of the quadrature encoder speed meter.
// ----------------------------------------------------------------------------
`include "quadrature_encoder_speed_meter_macros.svh"

module qesm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               window_closed,
  input logic signed [qesm_pkg::DIST_W-1:0] distance_out,
  input logic [qesm_pkg::SPEED_W-1:0]       speed_out,
  input logic [qesm_pkg::DIR_W-1:0]         direction
);
  import qesm_pkg::*;

  `QESM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(window_closed) && $stable(distance_out) && $stable(speed_out) && $stable(direction), "result changed while stalled")
  `QESM_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "item accepted on back-to-back cycles")
  `QESM_ASSERT_NOW(a_result_frees_input, clk, rst, $rose(out_valid), in_ready, "new result while still busy")
  `QESM_ASSERT_NOW(a_stop_no_speed, clk, rst, out_valid && direction == DIR_STOP, speed_out == '0, "speed nonzero while stopped")

endmodule

bind quadrature_encoder_speed_meter qesm_checker u_qesm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .window_closed (results.window_closed),
  .distance_out  (results.distance_out),
  .speed_out     (results.speed_out),
  .direction     (results.direction)
);
